FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned IDX_W = 11;

  localparam logic [7:0] CHAR_BLANK   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SETCUR = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } cell_t;

  typedef struct packed {
    logic [7:0]       attr;
    logic [7:0]       chr;
    logic [IDX_W-1:0] cursor;
  } result_t;

endpackage

FILE: rtl/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  tcw_pkg::cell_t        wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output tcw_pkg::cell_t        rdata_o
);

  tcw_pkg::cell_t mem [DEPTH];
  tcw_pkg::cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine
// Command sequencer: cursor, fill and scroll walks over the screen store.
// ----------------------------------------------------------------------------
module tcw_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcw_pkg::cmd_e                      cmd_i,
  input  logic [7:0]                         char_i,
  input  logic [tcw_pkg::IDX_W-1:0]          idx_i,
  input  logic [7:0]                         attr_i,
  output logic                               res_valid_o,
  output tcw_pkg::result_t                   res_o,
  input  logic                               out_free_i,
  output logic                               ram_we_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]    ram_waddr_o,
  output tcw_pkg::cell_t                     ram_wdata_o,
  output logic                               ram_re_o,
  output logic [$clog2(ROWS*COLUMNS)-1:0]    ram_raddr_o,
  input  tcw_pkg::cell_t                     ram_rdata_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = ((AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W) + 1;

  localparam logic [PW-1:0] CELLS_P   = PW'(CELLS);
  localparam logic [PW-1:0] COLS_P    = PW'(COLUMNS);
  localparam logic [PW-1:0] LASTROW_P = PW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] LASTCOL   = CW'(COLUMNS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FILL = 6'b000010,
    S_COPY = 6'b000100,
    S_READ = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   col_q, col_d;
  logic [PW-1:0]   fill_ptr_q, fill_ptr_d;
  logic [PW-1:0]   fill_end_q, fill_end_d;
  tcw_pkg::cell_t  fill_cell_q, fill_cell_d;
  logic            fill_adv_q, fill_adv_d;
  logic            fill_init_q, fill_init_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic            pend_q, pend_d;
  logic [PW-1:0]   rem_q, rem_d;
  logic [7:0]      rdch_q, rdch_d;
  logic [7:0]      rdat_q, rdat_d;

  logic [PW-1:0]   idx_w;
  logic [PW-1:0]   nxt_row;
  logic [PW-1:0]   fill_nxt;
  logic [PW-1:0]   adv_row;
  tcw_pkg::cell_t  blank;

  assign idx_w   = {{(PW-tcw_pkg::IDX_W){1'b0}}, idx_i};
  assign nxt_row = pos_q + COLS_P - {{(PW-CW){1'b0}}, col_q};
  assign fill_nxt = fill_ptr_q + PW'(1);
  assign blank   = '{attr: attr_i, chr: tcw_pkg::CHAR_BLANK};

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    col_d       = col_q;
    fill_ptr_d  = fill_ptr_q;
    fill_end_d  = fill_end_q;
    fill_cell_d = fill_cell_q;
    fill_adv_d  = fill_adv_q;
    fill_init_d = fill_init_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    pend_d      = pend_q;
    rem_d       = rem_q;
    rdch_d      = rdch_q;
    rdat_d      = rdat_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = pos_q[AW-1:0];
    ram_wdata_o = '{attr: attr_i, chr: char_i};
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_w[AW-1:0];
    res_valid_o = 1'b0;
    adv_row     = nxt_row;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rdch_d = '0;
          rdat_d = '0;
          unique case (cmd_i)
            tcw_pkg::CMD_PUT: begin
              if (char_i == tcw_pkg::CHAR_NEWLINE) begin
                fill_ptr_d  = pos_q;
                fill_end_d  = nxt_row;
                fill_cell_d = blank;
                fill_adv_d  = 1'b1;
                state_d     = S_FILL;
              end else begin
                ram_we_o = 1'b1;
                if (col_q != LASTCOL) begin
                  pos_d   = pos_q + PW'(1);
                  col_d   = col_q + CW'(1);
                  state_d = S_DONE;
                end else begin
                  col_d = '0;
                  if (nxt_row == CELLS_P) begin
                    pos_d    = LASTROW_P;
                    rd_ptr_d = COLS_P;
                    wr_ptr_d = '0;
                    pend_d   = 1'b0;
                    state_d  = S_COPY;
                  end else begin
                    pos_d   = nxt_row;
                    state_d = S_DONE;
                  end
                end
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              fill_ptr_d  = '0;
              fill_end_d  = CELLS_P;
              fill_cell_d = blank;
              fill_adv_d  = 1'b0;
              pos_d       = '0;
              col_d       = '0;
              state_d     = S_FILL;
            end
            tcw_pkg::CMD_READ: begin
              if (idx_w < CELLS_P) begin
                ram_re_o = 1'b1;
                state_d  = S_READ;
              end else begin
                state_d = S_DONE;
              end
            end
            tcw_pkg::CMD_SETCUR: begin
              if (idx_w < CELLS_P) begin
                pos_d   = idx_w;
                rem_d   = idx_w;
                state_d = S_DIV;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = fill_ptr_q[AW-1:0];
        ram_wdata_o = fill_cell_q;
        fill_ptr_d  = fill_nxt;
        adv_row     = fill_end_q;
        if (fill_nxt == fill_end_q) begin
          fill_init_d = 1'b0;
          fill_adv_d  = 1'b0;
          if (fill_init_q) begin
            state_d = S_IDLE;
          end else if (fill_adv_q) begin
            col_d = '0;
            if (adv_row == CELLS_P) begin
              pos_d    = LASTROW_P;
              rd_ptr_d = COLS_P;
              wr_ptr_d = '0;
              pend_d   = 1'b0;
              state_d  = S_COPY;
            end else begin
              pos_d   = adv_row;
              state_d = S_DONE;
            end
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_COPY: begin
        // read one row ahead, write each word back in the next cycle
        ram_raddr_o = rd_ptr_q[AW-1:0];
        ram_waddr_o = wr_ptr_q[AW-1:0];
        ram_wdata_o = ram_rdata_i;
        if (rd_ptr_q != CELLS_P) begin
          ram_re_o = 1'b1;
          rd_ptr_d = rd_ptr_q + PW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we_o = 1'b1;
          wr_ptr_d = wr_ptr_q + PW'(1);
        end
        if (rd_ptr_q == CELLS_P && !pend_q) begin
          fill_ptr_d  = LASTROW_P;
          fill_end_d  = CELLS_P;
          fill_cell_d = blank;
          fill_adv_d  = 1'b0;
          state_d     = S_FILL;
        end
      end
      S_READ: begin
        rdch_d  = ram_rdata_i.chr;
        rdat_d  = ram_rdata_i.attr;
        state_d = S_DONE;
      end
      S_DIV: begin
        if (rem_q >= COLS_P) begin
          rem_d = rem_q - COLS_P;
        end else begin
          col_d   = rem_q[CW-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = out_free_i;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign res_o      = '{attr: rdat_q, chr: rdch_q, cursor: pos_q[tcw_pkg::IDX_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      pos_q       <= '0;
      col_q       <= '0;
      fill_ptr_q  <= '0;
      fill_end_q  <= CELLS_P;
      fill_cell_q <= '{attr: tcw_pkg::ATTR_RESET, chr: tcw_pkg::CHAR_BLANK};
      fill_adv_q  <= 1'b0;
      fill_init_q <= 1'b1;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      fill_ptr_q  <= fill_ptr_d;
      fill_end_q  <= fill_end_d;
      fill_cell_q <= fill_cell_d;
      fill_adv_q  <= fill_adv_d;
      fill_init_q <= fill_init_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    rdch_q <= rdch_d;
    rdat_q <= rdat_d;
  end

endmodule

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console: character screen store with cursor, put/clear/read/set.
//
//   port group   dir  content
//   s_axis       in   tuser: cmd[1:0]; tdata: char_code[7:0], cell_index[18:8]
//   m_axis       out  tdata: cursor_offset[10:0], cell_char[18:11], cell_attr[26:19]
//   cfg          in   cfg_data_i: text_attr[7:0], always ready
//
// Set cursor finds the column by one subtract of COLUMNS per row; out-of-range
// read/set change nothing. Newline blanks the rest of the row, clear blanks
// the whole store; a scroll copies each row up through the store's read and
// write ports and blanks the last row. After reset the store is blanked before
// the first word is taken. One result slot; input is taken while it waits.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code, cell_index
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // cursor_offset, cell_char, cell_attr
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [7:0]               attr_q;
  logic                     out_vld_q;
  tcw_pkg::result_t         out_q;
  logic                     out_free;
  logic                     res_vld;
  tcw_pkg::result_t         res;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  tcw_pkg::cell_t           ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  tcw_pkg::cell_t           ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else if (cfg_valid_i) begin
      attr_q <= cfg_data_i;
    end
  end

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (tcw_pkg::cmd_e'(s_axis_tuser)),
    .char_i      (s_axis_tdata[7:0]),
    .idx_i       (s_axis_tdata[18:8]),
    .attr_i      (attr_q),
    .res_valid_o (res_vld),
    .res_o       (res),
    .out_free_i  (out_free),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= res_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q.attr, out_q.chr, out_q.cursor};

  // one word in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted while previous one in flight");

  // result only loaded into a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld && out_vld_q |-> m_axis_tready)
    else $error("result slot overwritten");

  // result handoff never overlaps input acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld |-> !s_axis_tready)
    else $error("result issued while idle");

endmodule
